// ===== rtl/nvsdp_pkg.sv =====
// nvsdp_pkg: shared types, constants and code decoders for the nvfp4 dot product unit
// no dependencies; used by nvsdp_fma and the top level
`timescale 1ns / 1ps

package nvsdp_pkg;

	typedef logic [31:0] fp32_t;

	localparam fp32_t CanonNan    = 32'h7FC0_0000;
	localparam fp32_t NegZero     = 32'h8000_0000;
	localparam fp32_t InvDivReset = 32'h3F80_0000;

	// request into the shared fused multiply-add unit
	typedef struct packed {
		logic  start;
		fp32_t a;
		fp32_t b;
		fp32_t c;
	} fma_req_t;

	// response from the shared fused multiply-add unit
	typedef struct packed {
		logic  done;
		fp32_t result;
	} fma_rsp_t;

	// e2m1 code to float32, bit 3 is the sign
	function automatic fp32_t decode_weight(input logic [3:0] code);
		fp32_t mag;
		case (code[2:0])
			3'd0:    mag = 32'h0000_0000;
			3'd1:    mag = 32'h3F00_0000;
			3'd2:    mag = 32'h3F80_0000;
			3'd3:    mag = 32'h3FC0_0000;
			3'd4:    mag = 32'h4000_0000;
			3'd5:    mag = 32'h4040_0000;
			3'd6:    mag = 32'h4080_0000;
			default: mag = 32'h40C0_0000;
		endcase
		return {code[3], mag[30:0]};
	endfunction

	// e4m3fn byte to float32, exact
	function automatic fp32_t decode_scale(input logic [7:0] code);
		logic [3:0] ex;
		logic [2:0] man;
		fp32_t      mag;
		fp32_t      res;
		ex  = code[6:3];
		man = code[2:0];
		if (ex == 4'hF && man == 3'h7) begin
			res = CanonNan;
		end else begin
			if (ex == 4'h0) begin
				// subnormal e4m3: man * 2^-9
				case (man)
					3'd0:    mag = 32'h0000_0000;
					3'd1:    mag = 32'h3B00_0000;
					3'd2:    mag = 32'h3B80_0000;
					3'd3:    mag = 32'h3BC0_0000;
					3'd4:    mag = 32'h3C00_0000;
					3'd5:    mag = 32'h3C20_0000;
					3'd6:    mag = 32'h3C40_0000;
					default: mag = 32'h3C60_0000;
				endcase
			end else begin
				mag = {1'b0, 8'({4'b0, ex}) + 8'd120, man, 20'b0};
			end
			res = {code[7], mag[30:0]};
		end
		return res;
	endfunction

endpackage

// ===== rtl/nvsdp_ifs.sv =====
// nvsdp channel interfaces: lane input, result output and configuration write
// depends on nothing; payload widths follow the block's field list
`timescale 1ns / 1ps

interface nvsdp_lane_if;
	logic        valid;
	logic        ready;
	logic [3:0]  weight_code;
	logic [7:0]  scale_code;
	logic [31:0] activation;
	logic        last_of_row;

	modport source (output valid, weight_code, scale_code, activation, last_of_row,
		input ready);
	modport sink (input valid, weight_code, scale_code, activation, last_of_row,
		output ready);
endinterface

interface nvsdp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] dot_sum;

	modport source (output valid, dot_sum, input ready);
	modport sink (input valid, dot_sum, output ready);
endinterface

interface nvsdp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] recip_div;

	modport source (output valid, recip_div, input ready);
	modport sink (input valid, recip_div, output ready);
endinterface

// ===== rtl/nvfp4_scaled_dot_product_unit.sv =====
// nvfp4_scaled_dot_product_unit: top level, lane sequencer, accumulator and result register
// depends on nvsdp_pkg, the nvsdp channel interfaces and nvsdp_fma
//
// usage: each lane transaction on "lane" carries an e2m1 weight code, the e4m3 block
// scale byte, a float32 activation and last_of_row. "cfg" writes the float32 inverse
// divisor, taken only between lanes: cfg.ready is high only while the block is idle.
// per lane the sequencer runs three operations through one shared float32 fused
// multiply-add unit (seven stages): scale = e4m3 * inverse divisor, w = weight * scale,
// acc = w * activation + acc. a lane therefore occupies the block until all three
// operations are done, and lane.ready is high only between lanes, so the next lane is
// not taken before the last one is through. on last_of_row the rounded sum goes to the
// output register, which raises result.valid; the accumulator restarts from +0.
// the output register lets the next lane be taken while a sum waits; a stalled receiver
// only holds the block at the end of the next row until the waiting sum is taken.
// nan sums come out as 0x7fc00000.
// reset: accumulator +0, inverse divisor 1.0, no result pending.
`timescale 1ns / 1ps

module nvfp4_scaled_dot_product_unit (
	input logic            clk,
	input logic            arst_n,
	nvsdp_cfg_if.sink      cfg,
	nvsdp_lane_if.sink     lane,
	nvsdp_result_if.source result
);
	import nvsdp_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ISSUE0 = 3'd1;
	localparam logic [2:0] ST_WAIT0  = 3'd2;
	localparam logic [2:0] ST_ISSUE1 = 3'd3;
	localparam logic [2:0] ST_WAIT1  = 3'd4;
	localparam logic [2:0] ST_ISSUE2 = 3'd5;
	localparam logic [2:0] ST_WAIT2  = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0] state_q;
	fp32_t      inv_div_q;
	fp32_t      acc_q;
	logic       out_valid_q;
	fp32_t      out_sum_q;
	logic [3:0] wcode_q;
	logic [7:0] scode_q;
	fp32_t      act_q;
	logic       last_q;
	fp32_t      tmp_q;

	fma_req_t req;
	fma_rsp_t rsp;
	logic     out_free;
	logic     row_done;

	nvsdp_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign cfg.ready      = (state_q == ST_IDLE);
	assign lane.ready     = (state_q == ST_IDLE);
	assign result.valid   = out_valid_q;
	assign result.dot_sum = out_sum_q;
	assign out_free       = !out_valid_q || result.ready;
	assign row_done       = (state_q == ST_FIN) && last_q && out_free;

	always_comb begin
		req.start = (state_q == ST_ISSUE0) || (state_q == ST_ISSUE1) ||
			(state_q == ST_ISSUE2);
		case (state_q)
			ST_ISSUE0: begin
				req.a = decode_scale(scode_q);
				req.b = inv_div_q;
				req.c = NegZero;
			end
			ST_ISSUE1: begin
				req.a = decode_weight(wcode_q);
				req.b = tmp_q;
				req.c = NegZero;
			end
			default: begin
				req.a = tmp_q;
				req.b = act_q;
				req.c = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inv_div_q   <= InvDivReset;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				inv_div_q <= cfg.recip_div;
			end
			if (row_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (lane.valid) state_q <= ST_ISSUE0;
				end
				ST_ISSUE0: state_q <= ST_WAIT0;
				ST_WAIT0: begin
					if (rsp.done) state_q <= ST_ISSUE1;
				end
				ST_ISSUE1: state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (rsp.done) state_q <= ST_ISSUE2;
				end
				ST_ISSUE2: state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (rsp.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						acc_q   <= tmp_q;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						// hand the row sum over and restart the accumulator
						acc_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (lane.valid && lane.ready) begin
			wcode_q <= lane.weight_code;
			scode_q <= lane.scale_code;
			act_q   <= lane.activation;
			last_q  <= lane.last_of_row;
		end
		if (rsp.done) begin
			tmp_q <= rsp.result;
		end
		if (row_done) begin
			out_sum_q <= tmp_q;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		lane.valid && lane.ready |=> state_q == ST_ISSUE0)
		else $error("lane transaction did not start the first operation");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_WAIT0 || state_q == ST_WAIT1 || state_q == ST_WAIT2))
		else $error("fma result arrived outside a wait state");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		row_done |=> out_valid_q && acc_q == '0)
		else $error("row end did not present the sum and clear the accumulator");

endmodule

// ===== rtl/nvsdp_fma.sv =====
// nvsdp_fma: seven-stage float32 fused multiply-add, a * b + c with one rne rounding
// depends on nvsdp_pkg; one operation in flight at a time under the top level sequencer
`timescale 1ns / 1ps

module nvsdp_fma (
	input  logic                clk,
	input  logic                arst_n,
	input  nvsdp_pkg::fma_req_t req,
	output nvsdp_pkg::fma_rsp_t rsp
);
	import nvsdp_pkg::*;

	function automatic logic [4:0] lzc24(input logic [23:0] x);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (x[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [6:0] lzc78(input logic [77:0] x);
		logic [6:0] n;
		n = 7'd78;
		for (int i = 0; i < 78; i++) begin
			if (x[i]) n = 7'(77 - i);
		end
		return n;
	endfunction

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1: unpack, specials, normalize a and b
	logic [23:0]       ma_s1, mb_s1, mc_s1;
	logic signed [11:0] ea_s1, eb_s1;
	logic [7:0]        ec_s1;
	logic              ps_s1, sub_s1, cz_s1, spec_s1;
	fp32_t             specv_s1;

	// stage 2: significand product
	logic [47:0]       p_s2;
	logic signed [11:0] es_s2;
	logic [23:0]       mc_s2;
	logic [7:0]        ec_s2;
	logic              ps_s2, sub_s2, cz_s2, spec_s2;
	fp32_t             specv_s2;

	// stage 3: alignment
	logic [77:0]       pw_s3, cw_s3;
	logic signed [11:0] b_s3;
	logic              ps_s3, sub_s3, spec_s3;
	fp32_t             specv_s3;

	// stage 4: add or subtract
	logic [77:0]       sum_s4;
	logic signed [11:0] b_s4;
	logic              sgn_s4, spec_s4;
	fp32_t             specv_s4;

	// stage 5: leading zero count
	logic [77:0]       sum_s5;
	logic [6:0]        lz_s5;
	logic signed [11:0] e_s5;
	logic              sgn_s5, zero_s5, spec_s5;
	fp32_t             specv_s5;

	// stage 6: normalize or denormalize
	logic [77:0]       n_s6;
	logic              st_s6, ovf_s6, sgn_s6, zero_s6, spec_s6;
	logic [7:0]        ef_s6;
	fp32_t             specv_s6;

	// stage 7: rounded result
	fp32_t             res_s7;

	// stage 1 logic
	logic              sa, sb, sc;
	logic [7:0]        ea, eb, ec;
	logic [22:0]       fa, fb, fc;
	logic              a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
	logic [23:0]       ma, mb;
	logic [4:0]        lza, lzb;
	logic              prod_inf, prod_zero, is_nan;
	logic              spec_c;
	fp32_t             specv_c;

	always_comb begin
		{sa, ea, fa} = req.a;
		{sb, eb, fb} = req.b;
		{sc, ec, fc} = req.c;
		a_zero = (ea == 8'h00) && (fa == '0);
		b_zero = (eb == 8'h00) && (fb == '0);
		c_zero = (ec == 8'h00) && (fc == '0);
		a_inf  = (ea == 8'hFF) && (fa == '0);
		b_inf  = (eb == 8'hFF) && (fb == '0);
		c_inf  = (ec == 8'hFF) && (fc == '0);
		a_nan  = (ea == 8'hFF) && (fa != '0);
		b_nan  = (eb == 8'hFF) && (fb != '0);
		c_nan  = (ec == 8'hFF) && (fc != '0);
		ma = {ea != 8'h00, fa};
		mb = {eb != 8'h00, fb};
		lza = lzc24(ma);
		lzb = lzc24(mb);
		prod_inf  = a_inf || b_inf;
		prod_zero = a_zero || b_zero;
		is_nan = a_nan || b_nan || c_nan || (a_inf && b_zero) || (a_zero && b_inf) ||
			(prod_inf && c_inf && ((sa ^ sb) != sc));
		spec_c  = 1'b1;
		specv_c = CanonNan;
		if (is_nan) begin
			specv_c = CanonNan;
		end else if (prod_inf) begin
			specv_c = {sa ^ sb, 8'hFF, 23'b0};
		end else if (c_inf) begin
			specv_c = {sc, 8'hFF, 23'b0};
		end else if (prod_zero) begin
			// zero product: result is c, two zeros add to +0 unless both negative
			specv_c = c_zero ? {(sa ^ sb) & sc, 31'b0} : req.c;
		end else begin
			spec_c = 1'b0;
		end
	end

	// stage 3 logic
	logic signed [11:0] sh;
	logic              clamp;
	logic [77:0]       cw0, pw_c, cw_c;
	logic signed [11:0] b_c;

	always_comb begin
		sh    = es_s2 - $signed({4'b0, ec_s2}) - 12'sd99;
		clamp = sh[11] && !cz_s2;
		cw0   = {1'b0, mc_s2, 53'b0};
		if (clamp) begin
			// product far below c: keep only a sticky bit
			pw_c = 78'd1;
			cw_c = cw0;
			b_c  = $signed({4'b0, ec_s2}) - 12'sd203;
		end else begin
			pw_c = {28'b0, p_s2, 2'b0};
			b_c  = es_s2 - 12'sd302;
			if (sh[11]) begin
				cw_c = cw0;
			end else if (sh >= 12'sd78) begin
				cw_c = {77'b0, |mc_s2};
			end else begin
				cw_c = cw0 >> sh[6:0];
				cw_c[0] = cw_c[0] | (|(cw0 & ((78'd1 << sh[6:0]) - 78'd1)));
			end
		end
	end

	// stage 4 logic
	logic        lt;
	logic [77:0] sum_c;
	logic        sgn_c;

	always_comb begin
		lt = pw_s3 < cw_s3;
		if (sub_s3) begin
			sum_c = lt ? (cw_s3 - pw_s3) : (pw_s3 - cw_s3);
			sgn_c = ps_s3 ^ lt;
		end else begin
			sum_c = pw_s3 + cw_s3;
			sgn_c = ps_s3;
		end
	end

	// stage 6 logic
	logic signed [11:0] r, amt, ra;
	logic [77:0]       n_c;
	logic              st_c;

	always_comb begin
		r   = (e_s5 < 12'sd1) ? (12'sd1 - e_s5) : 12'sd0;
		amt = $signed({5'b0, lz_s5}) - r;
		ra  = -amt;
		st_c = 1'b0;
		if (!amt[11]) begin
			n_c = sum_s5 << amt[6:0];
		end else if (ra >= 12'sd78) begin
			n_c  = '0;
			st_c = |sum_s5;
		end else begin
			n_c  = sum_s5 >> ra[6:0];
			st_c = |(sum_s5 & ((78'd1 << ra[6:0]) - 78'd1));
		end
	end

	// stage 7 logic
	logic        inc;
	logic [30:0] mag;
	fp32_t       res_c;

	always_comb begin
		inc = n_s6[53] & (st_s6 | (|n_s6[52:0]) | n_s6[54]);
		mag = {ef_s6, n_s6[76:54]} + 31'(inc);
		if (spec_s6) begin
			res_c = specv_s6;
		end else if (zero_s6) begin
			res_c = '0;
		end else if (ovf_s6) begin
			res_c = {sgn_s6, 8'hFF, 23'b0};
		end else begin
			res_c = {sgn_s6, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1    <= ma << lza;
		mb_s1    <= mb << lzb;
		ea_s1    <= $signed({4'b0, (ea == 8'h00) ? 8'd1 : ea}) - $signed({7'b0, lza});
		eb_s1    <= $signed({4'b0, (eb == 8'h00) ? 8'd1 : eb}) - $signed({7'b0, lzb});
		mc_s1    <= {ec != 8'h00, fc};
		ec_s1    <= (ec == 8'h00) ? 8'd1 : ec;
		ps_s1    <= sa ^ sb;
		sub_s1   <= sa ^ sb ^ sc;
		cz_s1    <= c_zero;
		spec_s1  <= spec_c;
		specv_s1 <= specv_c;

		p_s2     <= ma_s1 * mb_s1;
		es_s2    <= ea_s1 + eb_s1;
		mc_s2    <= mc_s1;
		ec_s2    <= ec_s1;
		ps_s2    <= ps_s1;
		sub_s2   <= sub_s1;
		cz_s2    <= cz_s1;
		spec_s2  <= spec_s1;
		specv_s2 <= specv_s1;

		pw_s3    <= pw_c;
		cw_s3    <= cw_c;
		b_s3     <= b_c;
		ps_s3    <= ps_s2;
		sub_s3   <= sub_s2;
		spec_s3  <= spec_s2;
		specv_s3 <= specv_s2;

		sum_s4   <= sum_c;
		b_s4     <= b_s3;
		sgn_s4   <= sgn_c;
		spec_s4  <= spec_s3;
		specv_s4 <= specv_s3;

		sum_s5   <= sum_s4;
		lz_s5    <= lzc78(sum_s4);
		e_s5     <= b_s4 + 12'sd204 - $signed({5'b0, lzc78(sum_s4)});
		sgn_s5   <= sgn_s4;
		zero_s5  <= (sum_s4 == '0);
		spec_s5  <= spec_s4;
		specv_s5 <= specv_s4;

		n_s6     <= n_c;
		st_s6    <= st_c;
		ef_s6    <= (e_s5 < 12'sd1) ? 8'd0 : e_s5[7:0];
		ovf_s6   <= (e_s5 > 12'sd254);
		sgn_s6   <= sgn_s5;
		zero_s6  <= zero_s5;
		spec_s6  <= spec_s5;
		specv_s6 <= specv_s5;

		res_s7   <= res_c;
	end

	assign rsp.done   = v_s7;
	assign rsp.result = res_s7;

endmodule
